/* rtl/ring_window_speed_estimator_macros.svh */
// Assertion helpers used by the estimator datapath.
// Each use expects clk and arst_n in scope.
`ifndef RING_WINDOW_SPEED_ESTIMATOR_MACROS_SVH
`define RING_WINDOW_SPEED_ESTIMATOR_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define RWSE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RWSE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/rwse_pkg.sv */
`timescale 1ns / 1ps

package rwse_pkg;

	localparam int WINDOW_SIZE = 16;
	localparam int IDX_W       = $clog2(WINDOW_SIZE);
	localparam int CNT_W       = $clog2(WINDOW_SIZE + 1);
	localparam int SUM_W       = 16 + $clog2(WINDOW_SIZE);
	localparam int RATE_W      = 10;
	localparam int PROD_W      = SUM_W + RATE_W;
	localparam int DIV         = WINDOW_SIZE - 1;
	localparam int RECIP_SH    = SUM_W;
	localparam int RECIP_W     = RECIP_SH + 1;
	localparam int QMUL_W      = SUM_W + RECIP_W;

	localparam logic [RECIP_W-1:0] RECIP   = RECIP_W'((64'd1 << RECIP_SH) / DIV);
	localparam logic [PROD_W-1:0]  SAT_LIM = PROD_W'(64'd65536 * DIV);
	localparam logic [SUM_W-1:0]   DIV_W   = SUM_W'(DIV);

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE    = 1'd1;

	localparam logic [15:0]       JUMP_THRESHOLD_RST = 16'd2048;
	localparam logic [RATE_W-1:0] SAMPLE_RATE_RST    = 10'd20;

	localparam logic [1:0] CMD_PUSH  = 2'd0;
	localparam logic [1:0] CMD_POP   = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_QUERY = 2'd3;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OVERWRITE = 2'd1;
	localparam logic [1:0] STATUS_POP_EMPTY = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [15:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [15:0] newest_sample;
		logic        is_empty;
		logic        is_full;
		logic [15:0] speed;
		logic [1:0]  status;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic walk_rd;
		logic newest_rd;
		logic mul;
		logic recip;
		logic fix;
	} ctrl_cmd_t;

	typedef struct packed {
		logic walk_last;
	} dp_status_t;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(WINDOW_SIZE - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

/* rtl/rwse_ram.sv */
`timescale 1ns / 1ps

module rwse_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/rwse_ctrl.sv */
`timescale 1ns / 1ps

module rwse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  rwse_pkg::dp_status_t dp_status,
	output rwse_pkg::ctrl_cmd_t  cmd
);

	import rwse_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_WALK   = 6'b000010,
		ST_NEWEST = 6'b000100,
		ST_MUL    = 6'b001000,
		ST_RECIP  = 6'b010000,
		ST_FIX    = 6'b100000
	} state_t;

	state_t state_q, state_d;

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_WALK;
				end
			end
			ST_WALK: begin
				cmd.walk_rd = 1'b1;
				if (dp_status.walk_last) begin
					state_d = ST_NEWEST;
				end
			end
			ST_NEWEST: begin
				cmd.newest_rd = 1'b1;
				state_d       = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RECIP;
			end
			ST_RECIP: begin
				cmd.recip = 1'b1;
				state_d   = ST_FIX;
			end
			ST_FIX: begin
				cmd.fix = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/rwse_dp.sv */
`timescale 1ns / 1ps

`include "ring_window_speed_estimator_macros.svh"

module rwse_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rwse_pkg::ctrl_cmd_t               cmd,
	output rwse_pkg::dp_status_t              dp_status,
	input  rwse_pkg::in_item_t                item,
	input  logic                              cfg_we,
	input  logic [rwse_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rwse_pkg::CFG_DATA_W-1:0]   cfg_data,
	output logic                              done,
	output rwse_pkg::out_item_t               result
);

	import rwse_pkg::*;

	// configuration
	logic [15:0]       thr_q;
	logic [RATE_W-1:0] rate_q;

	// ring control
	logic [WINDOW_SIZE-1:0] valid_q;
	logic [IDX_W-1:0]       oldest_q, oldest_d;
	logic [IDX_W-1:0]       newest_q, newest_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [1:0]             status_q, status_d;
	logic                   push_we;
	logic [IDX_W-1:0]       push_addr;

	// walk
	logic [IDX_W-1:0] walk_idx_q;
	logic [IDX_W-1:0] walk_cnt_q;
	logic [IDX_W-1:0] rd_addr;
	logic [15:0]      rd_data;
	logic             rd_walk_s1, rd_first_s1, rd_newest_s1, rd_hit_s1;
	logic [15:0]      smp;
	logic [15:0]      prev_q;
	logic [15:0]      diff;
	logic [SUM_W-1:0] sum_q;
	logic [15:0]      newest_smp_q;

	// scaling
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0]  plow_q;
	logic              sat_q;
	logic [QMUL_W-1:0] qmul;
	logic [15:0]       qest_q;
	logic [SUM_W-1:0]  rem;
	logic [15:0]       speed;

	logic      done_q;
	out_item_t res_q;

	always_comb begin
		oldest_d  = oldest_q;
		newest_d  = newest_q;
		count_d   = count_q;
		status_d  = STATUS_OK;
		push_we   = 1'b0;
		push_addr = ring_next(newest_q);
		unique case (item.command)
			CMD_PUSH: begin
				push_we  = 1'b1;
				newest_d = push_addr;
				if (count_q == CNT_W'(WINDOW_SIZE)) begin
					oldest_d = ring_next(oldest_q);
					status_d = STATUS_OVERWRITE;
				end else begin
					count_d = count_q + 1'b1;
				end
			end
			CMD_POP: begin
				if (count_q == '0) begin
					status_d = STATUS_POP_EMPTY;
				end else begin
					oldest_d = ring_next(oldest_q);
					count_d  = count_q - 1'b1;
				end
			end
			CMD_CLEAR: begin
				oldest_d = '0;
				newest_d = IDX_W'(WINDOW_SIZE - 1);
				count_d  = '0;
			end
			CMD_QUERY: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= JUMP_THRESHOLD_RST;
			rate_q <= SAMPLE_RATE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_JUMP_THRESHOLD: thr_q  <= cfg_data;
				REG_SAMPLE_RATE:    rate_q <= cfg_data[RATE_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			oldest_q <= '0;
			newest_q <= IDX_W'(WINDOW_SIZE - 1);
			count_q  <= '0;
			status_q <= STATUS_OK;
		end else if (cmd.accept) begin
			oldest_q <= oldest_d;
			newest_q <= newest_d;
			count_q  <= count_d;
			status_q <= status_d;
			if (push_we) begin
				valid_q[push_addr] <= 1'b1;
			end
		end
	end

	rwse_ram #(
		.WIDTH(16),
		.DEPTH(WINDOW_SIZE)
	) u_store (
		.clk  (clk),
		.we   (cmd.accept && push_we),
		.waddr(push_addr),
		.wdata(item.sample),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign rd_addr             = cmd.walk_rd ? walk_idx_q : newest_q;
	assign dp_status.walk_last = (walk_cnt_q == IDX_W'(WINDOW_SIZE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_cnt_q   <= '0;
			rd_walk_s1   <= 1'b0;
			rd_first_s1  <= 1'b0;
			rd_newest_s1 <= 1'b0;
			rd_hit_s1    <= 1'b0;
			walk_idx_q   <= '0;
		end else begin
			rd_walk_s1   <= cmd.walk_rd;
			rd_first_s1  <= cmd.walk_rd && (walk_cnt_q == '0);
			rd_newest_s1 <= cmd.newest_rd;
			rd_hit_s1    <= valid_q[rd_addr];
			if (cmd.accept) begin
				walk_idx_q <= oldest_d;
				walk_cnt_q <= '0;
			end else if (cmd.walk_rd) begin
				walk_idx_q <= ring_next(walk_idx_q);
				walk_cnt_q <= walk_cnt_q + 1'b1;
			end
		end
	end

	// a slot never written reads as zero
	assign smp  = rd_hit_s1 ? rd_data : '0;
	assign diff = (smp > prev_q) ? smp - prev_q : prev_q - smp;

	always_ff @(posedge clk) begin
		if (rd_walk_s1) begin
			prev_q <= smp;
			if (rd_first_s1) begin
				sum_q <= '0;
			end else if (diff < thr_q) begin
				sum_q <= sum_q + SUM_W'(diff);
			end
		end
		if (rd_newest_s1) begin
			newest_smp_q <= smp;
		end
	end

	// divide by the pair count: reciprocal estimate, then one correction; saturates to all ones
	assign qmul = QMUL_W'(prod_q[SUM_W-1:0]) * QMUL_W'(RECIP);
	assign rem  = plow_q - SUM_W'(qest_q) * DIV_W;

	always_comb begin
		if (sat_q) begin
			speed = 16'hFFFF;
		end else if (rem >= DIV_W) begin
			speed = qest_q + 1'b1;
		end else begin
			speed = qest_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= PROD_W'(sum_q) * PROD_W'(rate_q);
		end
		if (cmd.recip) begin
			sat_q  <= (prod_q >= SAT_LIM);
			plow_q <= prod_q[SUM_W-1:0];
		end
		if (cmd.fix) begin
			res_q.newest_sample <= newest_smp_q;
			res_q.is_empty      <= (count_q == '0);
			res_q.is_full       <= (count_q == CNT_W'(WINDOW_SIZE));
			res_q.speed         <= speed;
			res_q.status        <= status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.recip) begin
			qest_q <= qmul[RECIP_SH+15:RECIP_SH];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.fix;
		end
	end

	assign done   = done_q;
	assign result = res_q;

	`RWSE_ASSERT_SAME(a_count_range, 1'b1, count_q <= CNT_W'(WINDOW_SIZE), "held count beyond window")
	`RWSE_ASSERT_NEXT(a_fix_strobes, cmd.fix, done_q, "scale step without result strobe")
	`RWSE_ASSERT_NEXT(a_single_strobe, done_q, !done_q, "result strobe held for two cycles")

endmodule

/* rtl/ring_window_speed_estimator.sv */
`timescale 1ns / 1ps

// The result strobe done is registered from the fix step.
// A new command is taken only in idle, while busy is low; the pair walk reads one slot a
// cycle from the single store read port, then newest read, multiply, reciprocal and fix steps.
// The result shows for one cycle on done; the receiver cannot stall.
// Reset: empty ring, oldest/count 0, newest WINDOW_SIZE-1, store reads 0, registers at defaults.
module ring_window_speed_estimator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  rwse_pkg::in_item_t              item,
	output logic                            done,
	output rwse_pkg::out_item_t             result,
	input  logic                            cfg_we,
	input  logic [rwse_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rwse_pkg::CFG_DATA_W-1:0] cfg_data
);

	import rwse_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t dp_status;

	rwse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.dp_status(dp_status),
		.cmd      (cmd)
	);

	rwse_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.dp_status(dp_status),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.done     (done),
		.result   (result)
	);

endmodule
